// ===== rtl/apms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the mode timing table of the activity power mode selector.
// Depends on nothing; every other file of the block imports it.
package apms_pkg;

    localparam int ACCEL_W   = 16;
    localparam int AVG_W     = 16;
    localparam int RAD_W     = 32;
    localparam int ROOT_W    = 16;
    localparam int VOTE_W    = 7;
    localparam int NUM_AXES  = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DEFAULT_AVG_DEPTH  = 10;
    localparam int DEFAULT_VOTE_DEPTH = 10;

    localparam logic [AVG_W-1:0] ONE_G = 16'd8192;

    localparam logic [15:0]       REST_LIMIT_RST    = 16'd819;
    localparam logic [15:0]       WALK_LIMIT_RST    = 16'd4096;
    localparam logic [15:0]       SEIZURE_LIMIT_RST = 16'd12288;
    localparam logic [VOTE_W-1:0] RUN_NEED_RST      = 7'd6;
    localparam logic [VOTE_W-1:0] WALK_NEED_RST     = 7'd5;

    typedef enum logic [1:0] {
        CLS_REST = 2'd0,
        CLS_WALK = 2'd1,
        CLS_RUN  = 2'd2
    } act_class_e;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_MED  = 2'd1,
        MODE_HIGH = 2'd2
    } power_mode_e;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REST_LIMIT    = 3'd0,
        CFG_WALK_LIMIT    = 3'd1,
        CFG_SEIZURE_LIMIT = 3'd2,
        CFG_RUN_NEED      = 3'd3,
        CFG_WALK_NEED     = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
    } in_item_t;

    typedef struct packed {
        logic [14:0] sample_period_ms;
        logic [13:0] radio_on_ms;
        logic [5:0]  upload_period_hours;
        logic [8:0]  link_interval_ms;
        logic [3:0]  light_sleep_min;
        logic [3:0]  deep_sleep_min;
    } timing_t;

    typedef struct packed {
        logic [AVG_W-1:0] average_motion;
        logic [1:0]       activity_class;
        logic             seizure_flag;
        logic             window_done;
        logic [1:0]       power_mode;
        logic [14:0]      sample_period_ms;
        logic [13:0]      radio_on_ms;
        logic [5:0]       upload_period_hours;
        logic [8:0]       link_interval_ms;
        logic [3:0]       light_sleep_min;
        logic [3:0]       deep_sleep_min;
    } out_item_t;

    // Fixed timing set for each power mode.
    function automatic timing_t mode_timing(input power_mode_e mode);
        timing_t t;
        unique case (mode)
            MODE_LOW:  t = '{15'd20000, 14'd5000,  6'd48, 9'd500, 4'd2,  4'd5};
            MODE_HIGH: t = '{15'd5000,  14'd15000, 6'd12, 9'd50,  4'd10, 4'd15};
            default:   t = '{15'd10000, 14'd10000, 6'd24, 9'd100, 4'd5,  4'd10};
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/apms_hist_cell.sv =====
`timescale 1ns / 1ps
// One cell of the net motion delay line; passes its value to the next cell on each shift.
// Depends on apms_pkg for the value width.
module apms_hist_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       shift_en,
    input  logic [apms_pkg::AVG_W-1:0] d_in,
    output logic [apms_pkg::AVG_W-1:0] q_out
);
    import apms_pkg::*;

    logic [AVG_W-1:0] val_reg;

    // The history starts all zero so the running sum stays consistent.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val_reg <= '0;
        end else if (shift_en) begin
            val_reg <= d_in;
        end
    end

    assign q_out = val_reg;

endmodule

// ===== rtl/apms_isqrt.sv =====
`timescale 1ns / 1ps
// Iterative integer square root, one result bit per cycle, floored result.
// Depends on apms_pkg for the radicand and root widths.
module apms_isqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [apms_pkg::RAD_W-1:0]  radicand,
    output logic                        done,
    output logic [apms_pkg::ROOT_W-1:0] root
);
    import apms_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    // Bring down the next two radicand bits and try to set the next root bit.
    always_comb begin
        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // High in the cycle of the last step; root is final from the next cycle on.
    assign done = busy_reg && (cnt_reg == '0);
    assign root = root_reg;

endmodule

// ===== rtl/activity_power_mode_selector_core.sv =====
`timescale 1ns / 1ps
// Top level of the activity power mode selector: sequencer, delay line of cells, voter.
// Depends on apms_pkg, apms_hist_cell and apms_isqrt.
//
//  Channel   Direction  Handshake            Beat contents
//  s_        in         s_valid / s_ready    in_item_t: accel_x, accel_y, accel_z
//  m_        out        m_valid / m_ready    out_item_t: average, class, flags, mode timing
//  cfg_      in         cfg_wr_en            register index and write data, no read-back
//
// Each sample passes these steps from the accepting edge back to ready: accept it, square
// the three axes on the shared 16x16 squaring multiplier, launch the square root, run the
// bit-per-cycle square root unit, shift the delay line, do the reciprocal multiply that
// divides the sum by the window depth, and vote.
// Reset is synchronous and active low; it clears the delay line, sum and votes and
// returns the mode to medium.
// A result waits in the output register while m_ready is low; the final step holds until
// that register is free, and s_ready stays low until then.
module activity_power_mode_selector_core #(
    parameter int AVG_DEPTH  = apms_pkg::DEFAULT_AVG_DEPTH,
    parameter int VOTE_DEPTH = apms_pkg::DEFAULT_VOTE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  apms_pkg::in_item_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output apms_pkg::out_item_t             m_data,
    input  logic                            cfg_wr_en,
    input  logic [apms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [apms_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import apms_pkg::*;

    // The running sum grows by log2 of the window over one entry. Division by the window
    // depth is a multiply by a rounded-up reciprocal; with DIV_K chosen this way the floor
    // of the scaled product equals the true quotient for every reachable sum.
    localparam int SUM_W   = AVG_W + $clog2(AVG_DEPTH);
    localparam int DIV_K   = SUM_W + $clog2(AVG_DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int Q_W     = PROD_W - DIV_K;
    localparam longint RECIP_VAL = ((64'd1 << DIV_K) + AVG_DEPTH - 1) / AVG_DEPTH;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int WIN_W   = $clog2(VOTE_DEPTH);
    localparam int VCNT_W  = $clog2(VOTE_DEPTH + 1);

    // One-hot sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SQR   = 7'b0000010,
        ST_RGO   = 7'b0000100,
        ST_RWAIT = 7'b0001000,
        ST_UPD   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_e;

    state_e state_reg, state_next;

    // Configuration registers.
    logic [15:0]       rest_limit_reg;
    logic [15:0]       walk_limit_reg;
    logic [15:0]       seizure_limit_reg;
    logic [VOTE_W-1:0] run_need_reg;
    logic [VOTE_W-1:0] walk_need_reg;

    // Datapath registers.
    logic [ACCEL_W-1:0] abs_reg [NUM_AXES];
    logic [1:0]         sq_cnt_reg;
    logic [RAD_W-1:0]   acc_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PROD_W-1:0]  prod_reg;

    // Vote state.
    logic [VCNT_W-1:0] walk_votes_reg, run_votes_reg;
    logic [WIN_W-1:0]  win_cnt_reg;
    power_mode_e       mode_reg;

    // Output register.
    out_item_t out_reg;
    logic      out_valid_reg;

    // Square root unit and delay line.
    logic              root_start;
    logic              root_done;
    logic [ROOT_W-1:0] root_val;
    logic [AVG_W-1:0]  net;
    logic              hist_shift;
    logic [AVG_W-1:0]  hist_q [AVG_DEPTH];
    logic [AVG_W-1:0]  oldest;

    // Vote step signals.
    logic              out_free;
    logic [Q_W-1:0]    avg_q;
    logic [AVG_W-1:0]  avg;
    act_class_e        cls;
    logic              seizure;
    logic [VCNT_W-1:0] walk_sum, run_sum;
    logic              win_last;
    power_mode_e       mode_next;
    timing_t           timing;
    out_item_t         out_next;
    logic              s_fire;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (sq_cnt_reg == 2'(NUM_AXES - 1)) begin
                    state_next = ST_RGO;
                end
            end
            ST_RGO: begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT: begin
                if (root_done) begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration writes; an index outside the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rest_limit_reg    <= REST_LIMIT_RST;
            walk_limit_reg    <= WALK_LIMIT_RST;
            seizure_limit_reg <= SEIZURE_LIMIT_RST;
            run_need_reg      <= RUN_NEED_RST;
            walk_need_reg     <= WALK_NEED_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_REST_LIMIT:    rest_limit_reg    <= cfg_wr_data;
                CFG_WALK_LIMIT:    walk_limit_reg    <= cfg_wr_data;
                CFG_SEIZURE_LIMIT: seizure_limit_reg <= cfg_wr_data;
                CFG_RUN_NEED:      run_need_reg      <= cfg_wr_data[VOTE_W-1:0];
                CFG_WALK_NEED:     walk_need_reg     <= cfg_wr_data[VOTE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the absolute values of the three axes. The most negative count maps to
    // 32768, which still fits the unsigned 16-bit magnitude.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            abs_reg[0] <= s_data.accel_x[ACCEL_W-1] ? (~s_data.accel_x + 1'b1) : s_data.accel_x;
            abs_reg[1] <= s_data.accel_y[ACCEL_W-1] ? (~s_data.accel_y + 1'b1) : s_data.accel_y;
            abs_reg[2] <= s_data.accel_z[ACCEL_W-1] ? (~s_data.accel_z + 1'b1) : s_data.accel_z;
        end else if (state_reg == ST_SQR) begin
            // Rotate the next axis into the multiplier operand slot.
            abs_reg[0] <= abs_reg[1];
            abs_reg[1] <= abs_reg[2];
            abs_reg[2] <= abs_reg[0];
        end
    end

    // Sum of squares, one axis per cycle through a single multiplier. Three squares of
    // at most 2^30 each stay below 2^32.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_cnt_reg <= '0;
        end else if (s_fire) begin
            sq_cnt_reg <= '0;
        end else if (state_reg == ST_SQR) begin
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            acc_reg <= '0;
        end else if (state_reg == ST_SQR) begin
            acc_reg <= acc_reg + (RAD_W'(abs_reg[0]) * RAD_W'(abs_reg[0]));
        end
    end

    assign root_start = (state_reg == ST_RGO);

    apms_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (root_start),
        .radicand (acc_reg),
        .done     (root_done),
        .root     (root_val)
    );

    // Net motion is the distance of the magnitude from one g.
    assign net = (root_val >= ONE_G) ? (root_val - ONE_G) : (ONE_G - root_val);

    // Delay line as a row of cells: cell 0 takes the new value, each cell passes its
    // value on, and the last cell holds the entry that leaves the window.
    assign hist_shift = (state_reg == ST_UPD);

    for (genvar i = 0; i < AVG_DEPTH; i++) begin : g_hist
        if (i == 0) begin : g_head
            apms_hist_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (hist_shift),
                .d_in     (net),
                .q_out    (hist_q[i])
            );
        end else begin : g_body
            apms_hist_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (hist_shift),
                .d_in     (hist_q[i-1]),
                .q_out    (hist_q[i])
            );
        end
    end

    assign oldest = hist_q[AVG_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (hist_shift) begin
            sum_reg <= sum_reg - SUM_W'(oldest) + SUM_W'(net);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV) begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end
    end

    // Average, class and seizure flag.
    always_comb begin
        avg_q = prod_reg[PROD_W-1:DIV_K];
        avg   = (|avg_q[Q_W-1:AVG_W]) ? '1 : avg_q[AVG_W-1:0];
        if (avg < rest_limit_reg) begin
            cls = CLS_REST;
        end else if (avg < walk_limit_reg) begin
            cls = CLS_WALK;
        end else begin
            cls = CLS_RUN;
        end
        seizure = (cls == CLS_RUN) && (avg > seizure_limit_reg);
    end

    // Votes including this sample; the window closes on its last sample.
    always_comb begin
        walk_sum = walk_votes_reg + VCNT_W'(cls == CLS_WALK);
        run_sum  = run_votes_reg + VCNT_W'(cls == CLS_RUN);
        win_last = (win_cnt_reg == WIN_W'(VOTE_DEPTH - 1));
        mode_next = mode_reg;
        if (win_last) begin
            if (VOTE_W'(run_sum) >= run_need_reg) begin
                mode_next = MODE_HIGH;
            end else if (VOTE_W'(walk_sum) >= walk_need_reg) begin
                mode_next = MODE_MED;
            end else begin
                mode_next = MODE_LOW;
            end
        end
        timing = mode_timing(mode_next);
        out_next.average_motion      = avg;
        out_next.activity_class      = cls;
        out_next.seizure_flag        = seizure;
        out_next.window_done         = win_last;
        out_next.power_mode          = mode_next;
        out_next.sample_period_ms    = timing.sample_period_ms;
        out_next.radio_on_ms         = timing.radio_on_ms;
        out_next.upload_period_hours = timing.upload_period_hours;
        out_next.link_interval_ms    = timing.link_interval_ms;
        out_next.light_sleep_min     = timing.light_sleep_min;
        out_next.deep_sleep_min      = timing.deep_sleep_min;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_votes_reg <= '0;
            run_votes_reg  <= '0;
            win_cnt_reg    <= '0;
            mode_reg       <= MODE_MED;
        end else if ((state_reg == ST_FIN) && out_free) begin
            mode_reg <= mode_next;
            if (win_last) begin
                walk_votes_reg <= '0;
                run_votes_reg  <= '0;
                win_cnt_reg    <= '0;
            end else begin
                walk_votes_reg <= walk_sum;
                run_votes_reg  <= run_sum;
                win_cnt_reg    <= win_cnt_reg + 1'b1;
            end
        end
    end

    // Output register: loaded by the vote step, emptied by the downstream handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == ST_FIN) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_FIN) && out_free) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
